// ===== rtl/core/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg
// shared types and constants of the integer text formatter
// ----------------------------------------------------------------------------
package itf_pkg;

    localparam int MAX_WIDTH = 63;

    localparam logic [2:0] ACT_SDEC = 3'd0;
    localparam logic [2:0] ACT_UDEC = 3'd1;
    localparam logic [2:0] ACT_HEXL = 3'd2;
    localparam logic [2:0] ACT_HEXU = 3'd3;
    localparam logic [2:0] ACT_CHAR = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    // one decoded request, digits least significant first
    typedef struct packed {
        logic [9:0][3:0] digs;
        logic [3:0]      nd;
        logic            hex;
        logic            upper;
        logic            is_char;
        logic [7:0]      chr;
        logic [7:0]      sign;
        logic            left;
        logic            zpad;
        logic [5:0]      width;
    } itf_req_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10)
                c = CH_ZERO + {4'd0, d};
            else if (upper)
                c = 8'h41 + {4'd0, d} - 8'd10;
            else
                c = 8'h61 + {4'd0, d} - 8'd10;
            return c;
        end
    endfunction

endpackage

// ===== rtl/core/itf_bcd_stage.sv =====
// ----------------------------------------------------------------------------
// itf_bcd_stage
// one pipelined double-dabble stage: shifts in four binary bits
// ----------------------------------------------------------------------------
module itf_bcd_stage
    import itf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [39:0]     in_bcd,
    input  logic [31:0]     in_bin,
    input  itf_req_t        in_req,
    output logic            out_valid,
    output logic [39:0]     out_bcd,
    output logic [31:0]     out_bin,
    output itf_req_t        out_req
);

    logic        valid_reg;
    logic [39:0] bcd_reg;
    logic [31:0] bin_reg;
    itf_req_t    req_reg;
    logic [39:0] bcd_next;

    always_comb
    begin
        logic [39:0] b;
        b = in_bcd;
        for (int s = 0; s < 4; s++)
        begin
            for (int j = 0; j < 10; j++)
            begin
                if (b[j*4 +: 4] > 4'd4)
                    b[j*4 +: 4] = b[j*4 +: 4] + 4'd3;
            end
            b = {b[38:0], in_bin[31 - s]};
        end
        bcd_next = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bcd_reg <= bcd_next;
            bin_reg <= {in_bin[27:0], 4'd0};
            req_reg <= in_req;
        end
    end

    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;
    assign out_req   = req_reg;

endmodule

// ===== rtl/core/itf_emitter.sv =====
// ----------------------------------------------------------------------------
// itf_emitter
// walks one decoded request and emits its characters
// ----------------------------------------------------------------------------
module itf_emitter
    import itf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  itf_req_t   req,
    output logic       valid,
    input  logic       stall,
    output logic [7:0] out_char,
    output logic       last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;

    logic [1:0]  state_reg, state_next;
    itf_req_t    cur_reg, cur_next;
    logic [6:0]  pos_reg, pos_next;
    logic [3:0]  k_reg, k_next;
    logic [6:0]  total_reg, total_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  char_reg, char_next;
    logic        last_reg, last_next;

    logic [3:0]  k_in;
    logic [5:0]  w_in;
    logic [6:0]  pad_in;
    logic        out_free;
    logic [6:0]  pad;
    logic        has_sign;
    logic [6:0]  p;
    logic [6:0]  di;
    logic [3:0]  dig;
    logic [7:0]  ch;

    always_comb
    begin
        k_in = 4'd1;
        for (int i = 0; i < 10; i++)
        begin
            if (4'(i) < req.nd && req.digs[i] != 4'd0)
                k_in = 4'(i + 1);
        end
        w_in = (req.width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : req.width;
        pad_in = ({1'b0, w_in} > {3'd0, k_in}) ? ({1'b0, w_in} - {3'd0, k_in}) : 7'd0;
    end

    assign out_free  = !ovalid_reg || !stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign has_sign  = (cur_reg.sign != 8'd0);
    assign pad       = (cur_reg.width > {2'd0, k_reg}) ? ({1'b0, cur_reg.width} - {3'd0, k_reg})
                                                       : 7'd0;

    always_comb
    begin
        p = pos_reg;
        ch = CH_SPACE;
        di = 7'd0;
        if (cur_reg.is_char)
            ch = cur_reg.chr;
        else if (cur_reg.left)
        begin
            if (has_sign && p == 7'd0)
                ch = cur_reg.sign;
            else
            begin
                di = p - {6'd0, has_sign};
                if (di < {3'd0, k_reg})
                    ch = 8'hff;
            end
        end
        else
        begin
            if (p < pad)
                ch = cur_reg.zpad ? CH_ZERO : CH_SPACE;
            else if (has_sign && p == pad)
                ch = cur_reg.sign;
            else
            begin
                di = p - pad - {6'd0, has_sign};
                ch = 8'hff;
            end
        end
        dig = cur_reg.digs[4'({3'd0, k_reg} - 7'd1 - di)];
        if (ch == 8'hff && !cur_reg.is_char)
            ch = digit_char(dig, cur_reg.upper);
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        total_next  = total_reg;
        ovalid_next = ovalid_reg && stall;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_RUN;
                    cur_next = req;
                    cur_next.width = w_in;
                    k_next = k_in;
                    pos_next = 7'd0;
                    total_next = req.is_char ? 7'd1
                               : ({3'd0, k_in} + pad_in + {6'd0, req.sign != 8'd0});
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    char_next = ch;
                    last_next = (pos_reg + 7'd1 == total_reg);
                    pos_next = pos_reg + 7'd1;
                    if (pos_reg + 7'd1 == total_reg)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        pos_reg   <= pos_next;
        k_reg     <= k_next;
        total_reg <= total_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign valid    = ovalid_reg;
    assign out_char = char_reg;
    assign last     = last_reg;

endmodule

// ===== rtl/core/integer_text_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter_unit
// formats one integer conversion request as a stream of characters
// ----------------------------------------------------------------------------
// channel | direction | beat
// in      | input     | action, value, flags, field_width
// out     | output    | out_char, last
//
// a request passes a decode stage and eight binary-to-bcd stages, then the
// emitter sends one character per cycle while out is not stalled; it takes
// no new request until it has sent the last character of the one it holds.
// reset clears all valid bits and the emitter state.
// a stall on out freezes the emitter; the front pipeline then backs up.
module integer_text_formatter_unit
    import itf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [31:0] value,
    input  logic        left_align,
    input  logic        force_sign,
    input  logic        space_sign,
    input  logic        zero_pad,
    input  logic [5:0]  field_width,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        last
);

    localparam int NSTG = 8;

    logic            en;
    logic            em_stall;
    logic            d_valid_reg;
    logic [31:0]     d_bin_reg;
    itf_req_t        d_req_reg;
    itf_req_t        req_in;
    logic [31:0]     bin_in;
    logic [NSTG:0]       v;
    logic [NSTG:0][39:0] bcd;
    logic [NSTG:0][31:0] bin;
    itf_req_t [NSTG:0]   rq;
    itf_req_t        fin;

    assign en       = !(v[NSTG] && em_stall);
    assign in_stall = !en;

    always_comb
    begin
        logic neg;
        neg = (action == ACT_SDEC) && value[31];
        bin_in = neg ? (32'd0 - value) : value;
        req_in = '0;
        req_in.hex = (action == ACT_HEXL) || (action == ACT_HEXU);
        req_in.upper = (action == ACT_HEXU);
        req_in.is_char = (action == ACT_CHAR);
        req_in.chr = value[7:0];
        req_in.left = left_align;
        req_in.zpad = zero_pad && !left_align;
        req_in.width = field_width;
        req_in.nd = req_in.hex ? 4'd8 : 4'd10;
        for (int i = 0; i < 8; i++)
            req_in.digs[i] = value[i*4 +: 4];
        if (action == ACT_SDEC || action == ACT_UDEC)
            req_in.sign = neg ? CH_MINUS : force_sign ? CH_PLUS
                        : space_sign ? CH_SPACE : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= in_valid && (action <= ACT_CHAR);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_bin_reg <= bin_in;
            d_req_reg <= req_in;
        end
    end

    assign v[0]   = d_valid_reg;
    assign bcd[0] = '0;
    assign bin[0] = d_bin_reg;
    assign rq[0]  = d_req_reg;

    for (genvar g = 0; g < NSTG; g++)
    begin : g_bcd
        itf_bcd_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[g]),
            .in_bcd    (bcd[g]),
            .in_bin    (bin[g]),
            .in_req    (rq[g]),
            .out_valid (v[g+1]),
            .out_bcd   (bcd[g+1]),
            .out_bin   (bin[g+1]),
            .out_req   (rq[g+1])
        );
    end

    // decimal digits replace the raw nibbles
    always_comb
    begin
        fin = rq[NSTG];
        if (!fin.hex)
            fin.digs = bcd[NSTG];
    end

    itf_emitter u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (v[NSTG]),
        .req_stall (em_stall),
        .req       (fin),
        .valid     (out_valid),
        .stall     (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

// ===== bench/integer_text_formatter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter_unit_tb
// checks the character stream of the integer text formatter against a
// behavioral prediction: directed corner requests, then random requests,
// with random gaps on the request side and random stalls on the text side
// ----------------------------------------------------------------------------
module integer_text_formatter_unit_tb;

    import itf_pkg::*;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
        logic        left_align;
        logic        force_sign;
        logic        space_sign;
        logic        zero_pad;
        logic [5:0]  field_width;
    } request_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [31:0] value;
    logic        left_align;
    logic        force_sign;
    logic        space_sign;
    logic        zero_pad;
    logic [5:0]  field_width;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_char;
    logic        last;

    request_t   pending_reqs[$];
    text_char_t expected_text[$];
    int         errors;
    int         chars_seen;
    int         reqs_sent;
    int         cycles;
    int         send_gap;
    int         stall_left;
    bit         stim_done;
    bit         in_taken;

    integer_text_formatter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .value        (value),
        .left_align   (left_align),
        .force_sign   (force_sign),
        .space_sign   (space_sign),
        .zero_pad     (zero_pad),
        .field_width  (field_width),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            else
                return $urandom_range(8, 40);
        end
    endfunction

    // builds the expected text of one request
    task automatic format_request(input request_t rq);
        logic [7:0]  digs[10];
        logic [7:0]  sign;
        logic [31:0] mag;
        logic [7:0]  pad;
        text_char_t  seq[$];
        text_char_t  tc;
        int          k;
        int          nd;
        int          w;
        int          i;
        begin
            sign = 8'h00;
            k = 0;
            w = (rq.field_width > MAX_WIDTH) ? MAX_WIDTH : rq.field_width;
            if (rq.action == ACT_CHAR)
            begin
                tc.ch = rq.value[7:0];
                tc.last = 1'b1;
                expected_text.push_back(tc);
                return;
            end
            if (rq.action > ACT_CHAR)
                return;
            if (rq.action == ACT_SDEC || rq.action == ACT_UDEC)
            begin
                mag = rq.value;
                if (rq.action == ACT_SDEC && rq.value[31])
                begin
                    mag = -rq.value;
                    sign = CH_MINUS;
                end
                else if (rq.force_sign)
                    sign = CH_PLUS;
                else if (rq.space_sign)
                    sign = CH_SPACE;
                nd = 10;
                for (i = 9; i >= 0; i--)
                begin
                    digs[i] = CH_ZERO + 8'(mag % 10);
                    mag = mag / 10;
                end
                for (i = 0; i < 10; i++)
                    if (k == 0 && digs[i] != CH_ZERO)
                        k = 10 - i;
            end
            else
            begin
                nd = 8;
                for (i = 0; i < 8; i++)
                begin
                    mag = (rq.value >> (28 - 4 * i)) & 32'hf;
                    if (mag < 10)
                        digs[i] = CH_ZERO + 8'(mag);
                    else if (rq.action == ACT_HEXU)
                        digs[i] = 8'h41 + 8'(mag - 10);
                    else
                        digs[i] = 8'h61 + 8'(mag - 10);
                    if (k == 0 && mag != 0)
                        k = 8 - i;
                end
            end
            if (k == 0)
                k = 1;
            tc.last = 1'b0;
            if (rq.left_align)
            begin
                if (sign != 8'h00)
                begin
                    tc.ch = sign;
                    seq.push_back(tc);
                end
                for (i = nd - k; i < nd; i++)
                begin
                    tc.ch = digs[i];
                    seq.push_back(tc);
                end
                for (i = k; i < w; i++)
                begin
                    tc.ch = CH_SPACE;
                    seq.push_back(tc);
                end
            end
            else
            begin
                pad = rq.zero_pad ? CH_ZERO : CH_SPACE;
                for (i = k; i < w; i++)
                begin
                    tc.ch = pad;
                    seq.push_back(tc);
                end
                if (sign != 8'h00)
                begin
                    tc.ch = sign;
                    seq.push_back(tc);
                end
                for (i = nd - k; i < nd; i++)
                begin
                    tc.ch = digs[i];
                    seq.push_back(tc);
                end
            end
            seq[seq.size() - 1].last = 1'b1;
            foreach (seq[j])
                expected_text.push_back(seq[j]);
        end
    endtask

    function automatic request_t random_request();
        request_t    rq;
        logic [63:0] raw;
        int          r;
        begin
            raw = {$urandom, $urandom};
            rq = raw[$bits(request_t)-1:0];
            r = $urandom_range(0, 99);
            if (r < 92)
                rq.action = 3'($urandom_range(0, 4));
            if ($urandom_range(0, 9) < 8)
                rq.field_width = 6'($urandom_range(0, 14));
            r = $urandom_range(0, 9);
            if (r < 3)
                rq.value = $urandom_range(0, 999);
            else if (r < 4)
                rq.value = -$urandom_range(0, 999);
            return rq;
        end
    endfunction

    function automatic request_t make_req(input logic [2:0] a, input logic [31:0] v,
                                          input logic [3:0] flags, input logic [5:0] w);
        request_t rq;
        begin
            rq.action = a;
            rq.value = v;
            {rq.left_align, rq.force_sign, rq.space_sign, rq.zero_pad} = flags;
            rq.field_width = w;
            return rq;
        end
    endfunction

    initial
    begin
        pending_reqs.push_back(make_req(ACT_SDEC, 32'd0, 4'b0000, 6'd0));
        pending_reqs.push_back(make_req(ACT_SDEC, 32'h80000000, 4'b0000, 6'd0));
        pending_reqs.push_back(make_req(ACT_SDEC, 32'h7fffffff, 4'b0100, 6'd12));
        pending_reqs.push_back(make_req(ACT_SDEC, -32'd5, 4'b0001, 6'd4));
        pending_reqs.push_back(make_req(ACT_SDEC, 32'd42, 4'b0010, 6'd5));
        pending_reqs.push_back(make_req(ACT_SDEC, 32'd42, 4'b0110, 6'd1));
        pending_reqs.push_back(make_req(ACT_SDEC, -32'd1, 4'b1001, 6'd6));
        pending_reqs.push_back(make_req(ACT_SDEC, 32'd7, 4'b1100, 6'd63));
        pending_reqs.push_back(make_req(ACT_UDEC, 32'hffffffff, 4'b0111, 6'd0));
        pending_reqs.push_back(make_req(ACT_UDEC, 32'd0, 4'b1111, 6'd3));
        pending_reqs.push_back(make_req(ACT_UDEC, 32'd1000000000, 4'b0000, 6'd10));
        pending_reqs.push_back(make_req(ACT_HEXL, 32'hdeadbeef, 4'b0110, 6'd0));
        pending_reqs.push_back(make_req(ACT_HEXL, 32'd0, 4'b0001, 6'd8));
        pending_reqs.push_back(make_req(ACT_HEXU, 32'habc, 4'b0001, 6'd63));
        pending_reqs.push_back(make_req(ACT_HEXU, 32'hffffffff, 4'b1001, 6'd10));
        pending_reqs.push_back(make_req(ACT_HEXU, 32'h0f, 4'b1000, 6'd63));
        pending_reqs.push_back(make_req(ACT_CHAR, 32'hffffff41, 4'b1111, 6'd63));
        pending_reqs.push_back(make_req(ACT_CHAR, 32'h00000000, 4'b0000, 6'd0));
        pending_reqs.push_back(make_req(ACT_CHAR, 32'h000000ff, 4'b0000, 6'd5));
        pending_reqs.push_back(make_req(3'd5, 32'd123, 4'b0000, 6'd5));
        pending_reqs.push_back(make_req(3'd7, 32'hffffffff, 4'b1111, 6'd63));
        pending_reqs.push_back(make_req(ACT_SDEC, 32'd123, 4'b0000, 6'd63));
        repeat (400)
            pending_reqs.push_back(random_request());
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {action, value, left_align, force_sign, space_sign, zero_pad, field_width} = '0;
        errors = 0;
        chars_seen = 0;
        reqs_sent = 0;
        cycles = 0;
        send_gap = 0;
        stall_left = 0;
        stim_done = 1'b0;
        in_taken = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // request acceptance
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            format_request({action, value, left_align, force_sign, space_sign,
                            zero_pad, field_width});
            reqs_sent++;
            in_taken = 1'b1;
            send_gap = pick_gap();
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                in_taken = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    {action, value, left_align, force_sign, space_sign, zero_pad,
                     field_width} <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    stim_done = 1'b1;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                out_stall <= (stall_left > 0);
            end
        end
    end

    // text monitor
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            chars_seen++;
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected char %h last %b", $time, out_char, last);
                errors++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (out_char !== want.ch || last !== want.last)
                begin
                    $display("%0t: expected char %h last %b, got char %h last %b",
                             $time, want.ch, want.last, out_char, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (expected_text.size() > 0 && cycles < 400000)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (expected_text.size() > 0)
        begin
            $display("%0t: %0d expected chars never arrived", $time, expected_text.size());
            errors++;
        end
        $display("sent %0d requests, checked %0d characters under random gaps and stalls",
                 reqs_sent, chars_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 500000)
        begin
            $display("%0t: timeout", $time);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
